### rtl/latin_set_elimination_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set elimination block
// ----------------------------------------------------------------------------
`ifndef LATIN_SET_ELIMINATION_DEFINES_SVH
`define LATIN_SET_ELIMINATION_DEFINES_SVH
// check that a condition implies a consequence in the same cycle
`define LSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lse check failed");
// check that a condition implies a consequence in the next cycle
`define LSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lse check failed");
`endif

### rtl/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants of the set elimination block.
// ----------------------------------------------------------------------------
`default_nettype none
package lse_pkg;
  localparam int unsigned RowW = 16;
  localparam int unsigned DefMaxOrder = 16;
  localparam logic [4:0] OrderReset = 5'd9;

  localparam logic [1:0] OutNone = 2'd0;
  localparam logic [1:0] OutProgress = 2'd1;
  localparam logic [1:0] OutContra = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // store input beat
    logic init;     // build working copy, singles scan
    logic cols;     // map subset counter to columns
    logic eval;     // count zero rows for subset
    logic apply;    // clear bits
    logic restore;  // contradiction: restore originals
    logic commit;   // write result back
    logic step;     // advance subset counter
    logic emit_adv; // advance emit index
    logic emit_rst; // clear emit index
  } lse_cmd_t;

  typedef struct packed {
    logic        init_contra;
    logic        cnt_done;
    logic        size_ok;
    logic        zr_over;
    logic        zr_eq;
    logic        progress;
    logic        emit_last;
  } lse_sts_t;

  function automatic logic [4:0] popcnt16(input logic [15:0] v);
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < 16; i++) c = c + 5'(v[i]);
    return c;
  endfunction
endpackage
`default_nettype wire

### rtl/latin_set_elimination.sv
// ----------------------------------------------------------------------------
// latin_set_elimination
// Hidden-set elimination on one square boolean candidate matrix.
// ----------------------------------------------------------------------------
// Rows load at one beat per cycle in the load state; the beat marked last
// starts the search, which runs init and then walks the 2^n subset codes
// (n surviving rows) one code at a time: a code whose subset size is out of
// range is skipped, others go through map, count, check and, on a match,
// clear. A contradiction, progress or the end of the counter leads to write
// back. Results then leave one row per beat, order beats in all.
`default_nettype none
module latin_set_elimination import lse_pkg::*; #(
  parameter int unsigned MaxOrder = DefMaxOrder
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [1:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [RowW-1:0] row_bits_i,
  input  wire logic            row_last_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [RowW-1:0]      row_result_o,
  output logic [1:0]           outcome_o,
  output logic                 result_last_o
);
  logic [4:0] order_q;
  lse_cmd_t   cmd;
  lse_sts_t   sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, order_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) order_q <= OrderReset;
    else if (psel && penable && pwrite && paddr == 2'd0) order_q <= pwdata[4:0];
  end

  lse_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .row_last_i, .in_ready_o,
    .out_valid_o, .out_ready_i, .result_last_o, .cmd_o(cmd), .sts_i(sts)
  );

  lse_datapath #(.MaxOrder(MaxOrder)) u_dp (
    .clk_i, .rst_ni, .order_i(order_q), .cmd_i(cmd), .sts_o(sts),
    .row_bits_i, .row_result_o, .outcome_o
  );
endmodule
`default_nettype wire

### rtl/lse_datapath.sv
// ----------------------------------------------------------------------------
// lse_datapath
// Row store, working copy, masks, subset counter and the checks of one subset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "latin_set_elimination_defines.svh"
module lse_datapath import lse_pkg::*; #(
  parameter int unsigned MaxOrder = DefMaxOrder
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [4:0]      order_i,
  input  wire lse_cmd_t        cmd_i,
  output lse_sts_t             sts_o,
  input  wire logic [RowW-1:0] row_bits_i,
  output logic [RowW-1:0]      row_result_o,
  output logic [1:0]           outcome_o
);
  localparam int unsigned Lim = (MaxOrder < RowW) ? MaxOrder : RowW;
  localparam int unsigned IdxW = $clog2(Lim);

  logic [RowW-1:0] mat_q [Lim];
  logic [RowW-1:0] wrk_q [Lim];
  logic [4:0]  loaded_q;
  logic [RowW-1:0] lrow_q, lcol_q, sub_q;
  logic [RowW:0]   cnt_q;
  logic [4:0]  n_q, size_q, zr_q;
  logic [1:0]  res_q;
  logic [IdxW-1:0] emit_q;

  logic [4:0] eo;
  logic [RowW-1:0] omask;
  always_comb begin
    eo = (order_i == 5'd0) ? 5'd1 : order_i;
    if (eo > 5'(Lim)) eo = 5'(Lim);
    omask = RowW'((17'd1 << eo) - 17'd1);
  end

  // singles scan
  logic [RowW-1:0] s_lrow, s_lcol;
  logic            s_zero;
  always_comb begin
    s_lrow = '1; s_lcol = '1; s_zero = 1'b0;
    for (int i = 0; i < Lim; i++) begin
      if (5'(i) < eo) begin
        if ((mat_q[i] & omask) == '0) s_zero = 1'b1;
        if (popcnt16(mat_q[i] & omask) == 5'd1) begin
          s_lrow[i] = 1'b0;
          s_lcol = s_lcol & ~(mat_q[i] & omask);
        end
      end
    end
    s_lrow = s_lrow & omask;
    s_lcol = s_lcol & omask;
  end

  // subset bit k maps to the (n-1-k)th live column
  logic [RowW-1:0] c_sub;
  always_comb begin
    logic [4:0] pos;
    c_sub = '0;
    pos = '0;
    for (int j = RowW-1; j >= 0; j--) begin
      if (lcol_q[j]) begin
        if (pos < 5'd16 && cnt_q[pos[3:0]]) c_sub[j] = 1'b1;
        pos = pos + 5'd1;
      end
    end
  end

  logic [4:0] e_zr;
  always_comb begin
    e_zr = '0;
    for (int i = 0; i < Lim; i++)
      if (lrow_q[i] && (wrk_q[i] & sub_q) == '0) e_zr = e_zr + 5'd1;
  end

  logic [RowW-1:0] a_row [Lim];
  logic a_prog;
  always_comb begin
    a_prog = 1'b0;
    for (int i = 0; i < Lim; i++) begin
      a_row[i] = wrk_q[i];
      if (lrow_q[i] && (wrk_q[i] & sub_q) != '0 &&
          (wrk_q[i] & lcol_q & ~sub_q) != '0) begin
        a_row[i] = wrk_q[i] & ~(lcol_q & ~sub_q);
        a_prog = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      lrow_q <= '1; lcol_q <= '1; cnt_q <= '0;
      res_q <= OutNone; n_q <= '0; size_q <= '0; zr_q <= '0;
      emit_q <= '0; sub_q <= '0;
    end else begin
      if (cmd_i.load && loaded_q < 5'(Lim)) loaded_q <= loaded_q + 5'd1;
      if (cmd_i.init) begin
        lrow_q <= s_lrow; lcol_q <= s_lcol; cnt_q <= '0;
        n_q <= popcnt16(s_lrow);
        res_q <= OutNone;
        if (s_zero || popcnt16(s_lrow) != popcnt16(s_lcol)) res_q <= OutContra;
      end
      if (cmd_i.cols) begin
        sub_q <= c_sub; size_q <= popcnt16(cnt_q[RowW-1:0]);
      end
      if (cmd_i.eval) zr_q <= e_zr;
      if (cmd_i.apply && a_prog) res_q <= OutProgress;
      if (cmd_i.eval && e_zr > n_q - size_q) res_q <= OutContra;
      if (cmd_i.step) cnt_q <= cnt_q + 17'd1;
      if (cmd_i.commit) loaded_q <= '0;
      if (cmd_i.emit_rst) emit_q <= '0;
      else if (cmd_i.emit_adv) emit_q <= emit_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Lim; i++) begin
      if (cmd_i.load && loaded_q == 5'(i)) mat_q[i] <= row_bits_i;
      if (cmd_i.init) wrk_q[i] <= mat_q[i] & omask;
      if (cmd_i.apply) wrk_q[i] <= a_row[i];
      if (cmd_i.commit && !cmd_i.restore && 5'(i) < eo) mat_q[i] <= wrk_q[i];
      if (cmd_i.commit && cmd_i.restore && 5'(i) < eo) mat_q[i] <= mat_q[i] & omask;
    end
  end

  logic [4:0] ncnt;
  always_comb begin
    ncnt = n_q;
    sts_o.init_contra = (res_q == OutContra);
    sts_o.cnt_done    = (cnt_q >> ncnt) != '0;
    sts_o.size_ok     = popcnt16(cnt_q[RowW-1:0]) >= 5'd2 &&
                        popcnt16(cnt_q[RowW-1:0]) + 5'd1 < n_q;
    sts_o.zr_over     = zr_q > n_q - size_q;
    sts_o.zr_eq       = zr_q == n_q - size_q;
    sts_o.progress    = a_prog;
    sts_o.emit_last   = 5'(emit_q) + 5'd1 == eo;
  end

  assign row_result_o = mat_q[emit_q];
  assign outcome_o    = res_q;

  `LSE_ASSERT_IMP(a_res_code, clk_i, rst_ni, 1'b1, res_q != 2'd3)
  `LSE_ASSERT_IMP(a_load_cap, clk_i, rst_ni, 1'b1, loaded_q <= 5'(Lim))
  `LSE_ASSERT_NEXT(a_commit_clr, clk_i, rst_ni, cmd_i.commit && !cmd_i.load,
                   loaded_q == 5'd0)
endmodule
`default_nettype wire

### rtl/lse_ctrl.sv
// ----------------------------------------------------------------------------
// lse_ctrl
// Sequencer: load, singles scan, subset walk, write back and emit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "latin_set_elimination_defines.svh"
module lse_ctrl import lse_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic row_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic      result_last_o,
  output lse_cmd_t  cmd_o,
  input  wire lse_sts_t sts_i
);
  typedef enum logic [7:0] {
    SLoad  = 8'b0000_0001,
    SInit  = 8'b0000_0010,
    SCols  = 8'b0000_0100,
    SEval  = 8'b0000_1000,
    SChk   = 8'b0001_0000,
    SApply = 8'b0010_0000,
    SComm  = 8'b0100_0000,
    SEmit  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   contra;
  assign contra = sts_i.init_contra;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    result_last_o = 1'b0;
    unique case (state_q)
      SLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (row_last_i) state_d = SInit;
        end
      end
      SInit: begin
        cmd_o.init = 1'b1;
        state_d = SCols;
      end
      SCols: begin
        if (contra || sts_i.cnt_done) state_d = SComm;
        else if (!sts_i.size_ok) cmd_o.step = 1'b1;
        else begin
          cmd_o.cols = 1'b1;
          state_d = SEval;
        end
      end
      SEval: begin
        cmd_o.eval = 1'b1;
        state_d = SChk;
      end
      SChk: begin
        if (contra) state_d = SComm;
        else if (sts_i.zr_eq) state_d = SApply;
        else begin
          cmd_o.step = 1'b1;
          state_d = SCols;
        end
      end
      SApply: begin
        cmd_o.apply = 1'b1;
        if (sts_i.progress) state_d = SComm;
        else begin
          cmd_o.step = 1'b1;
          state_d = SCols;
        end
      end
      SComm: begin
        cmd_o.commit = 1'b1;
        cmd_o.restore = contra;
        cmd_o.emit_rst = 1'b1;
        state_d = SEmit;
      end
      SEmit: begin
        out_valid_o = 1'b1;
        result_last_o = sts_i.emit_last;
        if (out_ready_i) begin
          cmd_o.emit_adv = 1'b1;
          if (sts_i.emit_last) state_d = SLoad;
        end
      end
      default: state_d = SLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SLoad;
    else state_q <= state_d;
  end

  `LSE_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `LSE_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `LSE_ASSERT_NEXT(a_last_done, clk_i, rst_ni,
                   out_valid_o && out_ready_i && result_last_o, state_q == SLoad)
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: set elimination block testbench
// Loads candidate matrices row by row at several matrix orders, predicts the
// eliminated rows and their outcome code in a scoreboard, and checks every
// emitted row beat against it, with random bursts on the input side and
// random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import lse_pkg::*;

  localparam int unsigned LimitCycles = 20_000_000;
  localparam int unsigned NumItems = 380;
  localparam logic [1:0] OrderAddr = 2'd0;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [1:0]      outc;
    logic            last;
  } row_beat_t;

  class elim_scoreboard;
    logic [4:0]      order_reg;
    logic [RowW-1:0] stored[16];
    logic [RowW-1:0] work[16];
    int unsigned     loaded;
    row_beat_t       pending[$];
    int unsigned     errors;
    int unsigned     beats_checked;
    int unsigned     matrices;
    int unsigned     progress_seen;
    int unsigned     contra_seen;

    function new();
      order_reg = OrderReset;
      loaded = 0;
      errors = 0;
      beats_checked = 0;
      matrices = 0;
      progress_seen = 0;
      contra_seen = 0;
      foreach (stored[i]) stored[i] = '0;
    endfunction

    function int unsigned eff_order();
      int unsigned o;
      o = order_reg;
      if (o < 1) o = 1;
      if (o > 16) o = 16;
      return o;
    endfunction

    function logic [1:0] hidden_search(int unsigned o);
      logic [15:0] rmask, cmask, sub, clr;
      int unsigned cols[16];
      int unsigned n, m, size, zr, cnt, lim;
      bit prog;
      rmask = '1;
      cmask = '1;
      for (int i = 0; i < o; i++) begin
        if ($countones(work[i]) == 0) return OutContra;
        if ($countones(work[i]) == 1) begin
          rmask[i] = 1'b0;
          cmask &= ~work[i];
        end
      end
      lim = (1 << o) - 1;
      rmask &= lim[15:0];
      cmask &= lim[15:0];
      n = $countones(rmask);
      m = 0;
      for (int i = 0; i < o; i++) if (cmask[i]) cols[m++] = i;
      if (n != m) return OutContra;
      for (cnt = 0; cnt < (1 << n); cnt++) begin
        size = $countones(cnt);
        if (size < 2 || size + 1 >= n) continue;
        sub = '0;
        for (int k = 0; k < n; k++) if (cnt[k]) sub[cols[n-1-k]] = 1'b1;
        zr = 0;
        for (int i = 0; i < o; i++) if (rmask[i] && (work[i] & sub) == 0) zr++;
        if (zr > n - size) return OutContra;
        if (zr < n - size) continue;
        prog = 0;
        for (int i = 0; i < o; i++) begin
          if (!rmask[i] || (work[i] & sub) == 0) continue;
          clr = work[i] & cmask & ~sub;
          if (clr != 0) begin
            work[i] &= ~clr;
            prog = 1;
          end
        end
        if (prog) return OutProgress;
      end
      return OutNone;
    endfunction

    function void note_row(logic [RowW-1:0] bits, logic last);
      int unsigned o;
      logic [31:0] mask;
      logic [1:0] res;
      row_beat_t b;
      if (loaded < 16) begin
        stored[loaded] = bits;
        loaded++;
      end
      if (!last) return;
      o = eff_order();
      mask = (1 << o) - 1;
      for (int i = 0; i < o; i++) work[i] = stored[i] & mask[15:0];
      res = hidden_search(o);
      if (res == OutContra) begin
        for (int i = 0; i < o; i++) work[i] = stored[i] & mask[15:0];
        contra_seen++;
      end
      if (res == OutProgress) progress_seen++;
      for (int i = 0; i < o; i++) begin
        stored[i] = work[i];
        b.row = work[i];
        b.outc = res;
        b.last = (i + 1 == o);
        pending.push_back(b);
      end
      loaded = 0;
      matrices++;
    endfunction

    function void check_row(logic [RowW-1:0] row, logic [1:0] outc, logic last);
      row_beat_t e;
      beats_checked++;
      if (pending.size() == 0) begin
        $error("unexpected result beat: row_result %h outcome %0d", row, outc);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (row !== e.row) begin
        $error("row_result: expected %h, actual %h", e.row, row);
        errors++;
      end
      if (outc !== e.outc) begin
        $error("outcome: expected %0d, actual %0d", e.outc, outc);
        errors++;
      end
      if (last !== e.last) begin
        $error("result_last: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [1:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [RowW-1:0] row_bits_i = '0;
  logic            row_last_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [RowW-1:0] row_result_o;
  logic [1:0]      outcome_o;
  logic            result_last_o;

  elim_scoreboard sb = new();
  int unsigned cyc = 0;
  int unsigned items = 0;
  int unsigned burst_left = 0;
  bit          written[16];

  latin_set_elimination u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .row_bits_i, .row_last_i,
    .out_valid_o, .out_ready_i, .row_result_o, .outcome_o, .result_last_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side: stall pattern, timeout and checking
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    case ((cyc / 300) % 4)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      2: out_ready_i <= (cyc % 5 == 0);
      default: out_ready_i <= ($urandom_range(0, 9) != 0);
    endcase
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_row(row_result_o, outcome_o, result_last_o);
    if (cyc > LimitCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_row(logic [RowW-1:0] bits, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    row_bits_i <= bits;
    row_last_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_row(bits, last);
    items++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_order(logic [4:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= OrderAddr;
    pwdata <= {$urandom_range(0, 1) ? 27'h7ffffff : 27'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.order_reg = value;
  endtask

  // one matrix of count rows in the given style, the last one marked
  task automatic send_matrix(int unsigned style, int unsigned count);
    int unsigned o, ssz;
    logic [15:0] omask, smask, r;
    int q[$];
    int rq[$];
    bit sel[16];
    o = sb.eff_order();
    omask = 16'((32'h1 << o) - 1);
    smask = '0;
    foreach (sel[i]) sel[i] = 0;
    for (int i = 0; i < o; i++) q.push_back(i);
    q.shuffle();
    if (style == 2 && o >= 4) begin
      ssz = $urandom_range(2, o - 2);
      for (int i = 0; i < ssz; i++) smask[q[i]] = 1'b1;
      for (int i = 0; i < o; i++) rq.push_back(i);
      rq.shuffle();
      for (int i = 0; i < ssz; i++) sel[rq[i]] = 1;
    end
    for (int i = 0; i < count; i++) begin
      r = 16'($urandom);
      case (style)
        0: r = r | 16'($urandom);
        1: r = r & 16'($urandom);
        2: begin
          if (o < 4) r = r | 16'($urandom);
          else if (i < 16 && sel[i])
            r = (r & omask) | (16'h1 << q[$urandom_range(0, ssz - 1)]);
          else begin
            r = r & omask & ~smask;
            if (r == 0) r = 16'h1 << q[$urandom_range(ssz, o - 1)];
          end
          r = r | (16'($urandom) & ~omask);
        end
        default: begin
          if ($urandom_range(0, 3) == 0) r = r | 16'($urandom);
          else if ($urandom_range(0, 7) == 0) r = 16'h1 << $urandom_range(0, o - 1);
          else r = 16'h1 << q[i % o];
          r = r | (16'($urandom) & ~omask);
        end
      endcase
      if (i < 16) written[i] = 1;
      send_row(r, i + 1 == count);
    end
  endtask

  initial begin
    int unsigned o, cnt, style;
    bit short_ok;
    foreach (written[i]) written[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: order one, an empty row, a full row
    write_order(5'd1);
    send_row(16'h0000, 1'b1);
    send_row(16'hffff, 1'b1);
    // a hidden pair in order four
    write_order(5'd4);
    send_row(16'hffff, 1'b0);
    send_row(16'h000f, 1'b0);
    send_row(16'h000c, 1'b0);
    send_row(16'hfffc, 1'b1);
    // full order, every candidate open: the whole subset walk
    write_order(5'd16);
    for (int i = 0; i < 16; i++) begin
      written[i] = 1;
      send_row(16'hffff, i == 15);
    end

    while (items < NumItems) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 9))
          0: write_order(5'd0);
          1: write_order(5'($urandom_range(11, 31)));
          2: write_order(5'd1);
          default: write_order(5'($urandom_range(2, 10)));
        endcase
      end
      o = sb.eff_order();
      style = (o >= 11) ? 3 : $urandom_range(0, 5);
      if (style > 3) style = 2;
      cnt = o;
      if ($urandom_range(0, 7) == 0) begin
        cnt = $urandom_range(o, 20);
      end else if ($urandom_range(0, 7) == 0 && o > 1) begin
        cnt = $urandom_range(1, o - 1);
        short_ok = 1;
        for (int i = cnt; i < o; i++) if (!written[i]) short_ok = 0;
        if (!short_ok) cnt = o;
      end
      send_matrix(style, cnt);
    end

    drain();
    $display("%0d rows sent in %0d matrices, %0d result beats checked",
             items, sb.matrices, sb.beats_checked);
    $display("%0d searches made progress, %0d ended in contradiction",
             sb.progress_seen, sb.contra_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### latin_set_elimination.f
+incdir+rtl
rtl/lse_pkg.sv
rtl/lse_datapath.sv
rtl/lse_ctrl.sv
rtl/latin_set_elimination.sv
tb/sv/tb_top.sv
